// ===== rtl/core/bba_pkg.sv =====
// Shared constants, command codes and transaction types of the bitmap block allocator.
package bba_pkg;

    // Map geometry
    localparam int MAP_BITS   = 80;
    localparam int HALF_BITS  = MAP_BITS / 2;
    localparam int DIGIT_W    = 8;
    localparam int NUM_DIGITS = (MAP_BITS + DIGIT_W - 1) / DIGIT_W;
    localparam int PAD_BITS   = NUM_DIGITS * DIGIT_W;

    // Field and counter widths
    localparam int INDEX_W = 7;
    localparam int POS_W   = $clog2(PAD_BITS + 1);
    localparam int CMP_W   = (POS_W > INDEX_W) ? POS_W : INDEX_W;
    localparam int CNT_W   = $clog2(NUM_DIGITS);
    localparam int OFF_W   = $clog2(DIGIT_W);

    // Command codes
    localparam logic [1:0] CMD_FIND   = 2'd0;
    localparam logic [1:0] CMD_TOGGLE = 2'd1;
    localparam logic [1:0] CMD_FILL   = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    // Region codes
    localparam logic [1:0] RGN_LOWER = 2'd0;
    localparam logic [1:0] RGN_UPPER = 2'd1;
    localparam logic [1:0] RGN_WHOLE = 2'd2;

    // Input transaction
    typedef struct packed {
        logic [1:0]         cmd;
        logic [1:0]         region;
        logic               wanted_value;
        logic [INDEX_W-1:0] bit_index;
    } t_req;

    // Result transaction
    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] found_index;
    } t_rsp;

    // Per-digit lane outcome
    typedef struct packed {
        logic [DIGIT_W-1:0] new_digit;
        logic               hit;
        logic [OFF_W-1:0]   hit_off;
    } t_lane_out;

endpackage

// ===== rtl/core/bba_lane.sv =====
// One digit of the map: applies the command and searches for a matching bit.
module bba_lane
    import bba_pkg::*;
(
    input  t_req               i_req,
    input  logic [CMP_W-1:0]   i_base,
    input  logic [DIGIT_W-1:0] i_digit,
    output t_lane_out          o_lane
);

    logic [CMP_W-1:0]   lo;
    logic [CMP_W-1:0]   hi;
    logic               rgn_ok;
    logic [CMP_W-1:0]   pos;
    logic [DIGIT_W-1:0] in_rgn;
    logic [DIGIT_W-1:0] in_map;
    logic [DIGIT_W-1:0] is_idx;
    logic [DIGIT_W-1:0] match;

    // Decode region bounds; an unknown region means the whole map for find, nothing else
    always_comb begin
        lo     = '0;
        hi     = CMP_W'(MAP_BITS);
        rgn_ok = 1'b1;
        unique case (i_req.region)
            RGN_LOWER: hi = CMP_W'(HALF_BITS);
            RGN_UPPER: lo = CMP_W'(HALF_BITS);
            RGN_WHOLE: ;
            default:   rgn_ok = (i_req.cmd == CMD_FIND);
        endcase
    end

    // Classify each bit position of the digit
    always_comb begin
        pos    = '0;
        in_rgn = '0;
        in_map = '0;
        is_idx = '0;
        for (int j = 0; j < DIGIT_W; j++) begin
            pos       = i_base + CMP_W'(j);
            in_map[j] = (pos < CMP_W'(MAP_BITS));
            in_rgn[j] = rgn_ok && (pos >= lo) && (pos < hi);
            is_idx[j] = in_map[j] && (pos == CMP_W'(i_req.bit_index));
        end
    end

    // Apply the command to the digit
    always_comb begin
        unique case (i_req.cmd)
            CMD_FIND:   o_lane.new_digit = i_digit;
            CMD_TOGGLE: o_lane.new_digit = i_digit ^ is_idx;
            CMD_FILL:   o_lane.new_digit = i_digit | in_rgn;
            CMD_CLEAR:  o_lane.new_digit = i_digit & ~in_rgn;
            default:    o_lane.new_digit = i_digit;
        endcase
    end

    // Find the lowest matching bit in the digit
    always_comb begin
        match          = in_rgn & ~(i_digit ^ {DIGIT_W{i_req.wanted_value}});
        o_lane.hit     = |match;
        o_lane.hit_off = '0;
        for (int j = DIGIT_W - 1; j >= 0; j--) begin
            if (match[j]) begin
                o_lane.hit_off = OFF_W'(j);
            end
        end
    end

endmodule

// ===== rtl/core/bitmap_block_allocator_core.sv =====
// Top level of the bitmap block allocator: digit-serial map rotation and command sequencing.
//
//   channel   direction  handshake                 payload
//   command   in         start, busy               i_req    (t_req)
//   result    out        o_done (one-cycle strobe) o_result (t_rsp)
//
// Each command rotates the map through one 8-bit lane, one digit per cycle,
// over all NUM_DIGITS digits; the result strobes in the cycle after the last
// digit, and a new command is taken in that same cycle.
// Synchronous reset clears the map and the control state.
// Results cannot be stalled; busy holds off new commands while a scan runs.
module bitmap_block_allocator_core
    import bba_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_done,
    output t_rsp o_result
);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [CMP_W-1:0]    r_base;
    t_req                r_req;
    logic [PAD_BITS-1:0] r_map;
    logic                r_found;
    logic [INDEX_W-1:0]  r_found_index;
    t_lane_out           lane;
    logic [CMP_W-1:0]    n_hit_pos;
    logic                accept;

    assign accept    = start && !r_busy;
    assign n_hit_pos = r_base + CMP_W'(lane.hit_off);

    // Process the lowest digit of the map
    bba_lane u_lane (
        .i_req   (r_req),
        .i_base  (r_base),
        .i_digit (r_map[DIGIT_W-1:0]),
        .o_lane  (lane)
    );

    // Sequence control and rotate the map one digit per cycle while busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_base <= '0;
            r_map  <= '0;
        end else begin
            r_done <= 1'b0;
            if (accept) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_base <= '0;
            end else if (r_busy) begin
                r_map  <= {lane.new_digit, r_map[PAD_BITS-1:DIGIT_W]};
                r_cnt  <= r_cnt + CNT_W'(1);
                r_base <= r_base + CMP_W'(DIGIT_W);
                if (r_cnt == CNT_W'(NUM_DIGITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Capture the command and keep the first match of a find
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req         <= i_req;
            r_found       <= 1'b0;
            r_found_index <= '0;
        end else if (r_busy && (r_req.cmd == CMD_FIND) && !r_found && lane.hit) begin
            r_found       <= 1'b1;
            r_found_index <= n_hit_pos[INDEX_W-1:0];
        end
    end

    // Drive the ports
    assign busy                 = r_busy;
    assign o_done               = r_done;
    assign o_result.found       = r_found;
    assign o_result.found_index = r_found_index;

endmodule
